[hdl/hef_pkg.sv]
package hef_pkg;

  localparam int COUNT_BITS = 16;
  localparam int CAP_W      = 16;
  localparam int LIMIT_W    = 8;
  localparam int CFG_W      = 16;
  localparam int CMP_W      = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 1;

  localparam logic [CAP_W-1:0]   CAP_RST   = CAP_W'(256);
  localparam logic [LIMIT_W-1:0] LIMIT_RST = '0;

  // configuration register indexes
  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_NL_LIMIT = 1'b1;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NUL  = 2'd1;
  localparam logic [1:0] ST_ROOM = 2'd2;

  // what the character part of a result sequence is made of
  localparam logic [2:0] K_NONE  = 3'd0;
  localparam logic [2:0] K_PLAIN = 3'd1;
  localparam logic [2:0] K_LT    = 3'd2;
  localparam logic [2:0] K_GT    = 3'd3;
  localparam logic [2:0] K_AMP   = 3'd4;
  localparam logic [2:0] K_QUOT  = 3'd5;
  localparam logic [2:0] K_APOS  = 3'd6;
  localparam logic [2:0] K_BR    = 3'd7;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_LO   = 8'd32;
  localparam logic [7:0] CH_HI   = 8'd126;

  typedef struct packed {
    logic [COUNT_BITS-1:0] cnt;
    logic [LIMIT_W-1:0]    run;
    logic                  disc;
  } hef_state_t;

  typedef struct packed {
    logic [2:0]  kind;     // character source
    logic [2:0]  len;      // character results
    logic        trailer;  // terminator or status result follows
    logic [1:0]  status;
    logic [2:0]  nres;     // total results for the item
    hef_state_t  st_nxt;   // state once the item is retired
  } hef_plan_t;

  // byte idx of the sequence named by kind
  function automatic logic [7:0] seq_byte(input logic [2:0] kind, input logic [2:0] idx,
                                          input logic [7:0] data);
    logic [47:0] s;
    logic [5:0]  ofs;
    s   = '0;
    ofs = 6'd47 - {idx, 3'b000};
    case (kind)
      K_LT:    s = {"&lt;", 16'h0000};
      K_GT:    s = {"&gt;", 16'h0000};
      K_AMP:   s = {"&amp;", 8'h00};
      K_QUOT:  s = "&quot;";
      K_APOS:  s = "&apos;";
      K_BR:    s = {"<br>", 16'h0000};
      K_PLAIN: s = {data, 40'h0};
      default: s = '0;
    endcase
    return s[ofs -: 8];
  endfunction

endpackage

[hdl/html_escape_filter_top.sv]
// HTML escape filter.
// Input channel (in_valid/in_ready): one message byte per transfer, in_last_byte
// on its final byte. Result channel (out_valid/out_ready): one escaped character
// per transfer, with out_run_last on the last result of an input byte, and a
// closing result (out_byte 0, out_message_done 1) carrying out_status at the end
// of each message or on failure.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 output
// capacity, 1 newline limit) in the same edge; write only while idle.
// The first result of a byte is presented once the byte has passed the item
// register and its result the output register. While the output is not
// stalled, the output register takes one result each cycle: plain bytes
// stream at one per cycle, entities and line breaks hold the input for their
// extra characters. A byte with no result retires even under an output stall.
// Stall: when out_ready is low the output register holds; the item register
// behind it fills and then in_ready drops.
// Reset (rst_n low, synchronous): both channels empty, message state cleared,
// capacity 256 and newline limit 0.
module html_escape_filter_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        out_run_last,
  output logic                        out_message_done,
  output logic [1:0]                  out_status,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [hef_pkg::CFG_W-1:0]   cfg_data
);

  logic [hef_pkg::CAP_W-1:0]   cap_r;
  logic [hef_pkg::LIMIT_W-1:0] limit_r;
  hef_pkg::hef_state_t         st_r;

  logic                        item_valid_r;
  logic [7:0]                  item_data_r;
  logic                        item_last_r;
  logic [2:0]                  idx_r;

  logic                        out_valid_r;
  logic [7:0]                  out_byte_r;
  logic                        out_run_last_r;
  logic                        out_done_r;
  logic [1:0]                  out_status_r;

  hef_pkg::hef_plan_t          plan;
  logic                        out_free;
  logic                        emit;
  logic                        is_final;
  logic                        item_done;
  logic                        in_xfer;
  logic [7:0]                  res_byte;
  logic                        res_done;
  logic [1:0]                  res_status;

  hef_plan u_plan (
    .data  (item_data_r),
    .last  (item_last_r),
    .st    (st_r),
    .cap   (cap_r),
    .limit (limit_r),
    .plan  (plan)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign emit      = item_valid_r && (plan.nres != 3'd0) && out_free;
  assign is_final  = idx_r == (plan.nres - 3'd1);
  assign item_done = item_valid_r && ((plan.nres == 3'd0) || (out_free && is_final));
  assign in_ready  = !item_valid_r || item_done;
  assign in_xfer   = in_valid && in_ready;

  always_comb begin
    if (idx_r < plan.len) begin
      res_byte   = hef_pkg::seq_byte(plan.kind, idx_r, item_data_r);
      res_done   = 1'b0;
      res_status = hef_pkg::ST_OK;
    end else begin
      res_byte   = 8'h00;
      res_done   = 1'b1;
      res_status = plan.status;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= hef_pkg::CAP_RST;
      limit_r <= hef_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        hef_pkg::REG_CAPACITY: cap_r   <= cfg_data[hef_pkg::CAP_W-1:0];
        hef_pkg::REG_NL_LIMIT: limit_r <= cfg_data[hef_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // item register and result index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      idx_r        <= '0;
      st_r         <= '0;
    end else begin
      if (item_done) st_r <= plan.st_nxt;
      if (in_ready) item_valid_r <= in_valid;
      if (item_done) idx_r <= '0;
      else if (emit) idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_data_r <= in_data_byte;
      item_last_r <= in_last_byte;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r     <= res_byte;
      out_run_last_r <= is_final;
      out_done_r     <= res_done;
      out_status_r   <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_run_last     = out_run_last_r;
  assign out_message_done = out_done_r;
  assign out_status       = out_status_r;

  // index never runs past the item's result count
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && (plan.nres != 3'd0) |-> idx_r < plan.nres)
    else $error("result index out of range");

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid_r |-> idx_r == 3'd0)
    else $error("result index not cleared while idle");

  // discarding only follows a failure, which clears the message counters
  a_disc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.disc |-> (st_r.cnt == '0) && (st_r.run == '0))
    else $error("counters not cleared while discarding");

  // an error status appears only on a closing result
  a_status_close: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != hef_pkg::ST_OK) |->
      out_done_r && out_run_last_r && (out_byte_r == 8'h00))
    else $error("error status on a character result");

endmodule

[hdl/hef_plan.sv]
module hef_plan (
  input  logic [7:0]                  data,
  input  logic                        last,
  input  hef_pkg::hef_state_t         st,
  input  logic [hef_pkg::CAP_W-1:0]   cap,
  input  logic [hef_pkg::LIMIT_W-1:0] limit,
  output hef_pkg::hef_plan_t          plan
);

  logic [2:0]                     kind;
  logic [2:0]                     need;
  logic                           is_seq;
  logic                           run_inc;
  logic                           room;
  logic [1:0]                     fail;
  logic                           trailer;
  logic [hef_pkg::CMP_W-1:0]      cnt_x;
  logic [hef_pkg::CMP_W-1:0]      cap_x;
  logic [hef_pkg::CMP_W-1:0]      sum;
  logic [hef_pkg::COUNT_BITS-1:0] cnt_new;
  logic [hef_pkg::LIMIT_W-1:0]    run_new;
  logic                           disc_new;

  assign cnt_x = hef_pkg::CMP_W'(st.cnt);
  assign cap_x = hef_pkg::CMP_W'(cap);

  always_comb begin
    kind     = hef_pkg::K_NONE;
    need     = 3'd0;
    is_seq   = 1'b0;
    run_inc  = 1'b0;
    fail     = hef_pkg::ST_OK;
    trailer  = 1'b0;
    room     = 1'b1;
    sum      = cnt_x;
    cnt_new  = st.cnt;
    run_new  = st.run;
    disc_new = st.disc;
    if (st.disc) begin
      // swallow the rest of a failed message
      if (last) begin
        cnt_new  = '0;
        run_new  = '0;
        disc_new = 1'b0;
      end
    end else begin
      case (data)
        hef_pkg::CH_NUL:  fail = hef_pkg::ST_NUL;
        hef_pkg::CH_LT:   begin is_seq = 1'b1; kind = hef_pkg::K_LT;   need = 3'd4; end
        hef_pkg::CH_GT:   begin is_seq = 1'b1; kind = hef_pkg::K_GT;   need = 3'd4; end
        hef_pkg::CH_AMP:  begin is_seq = 1'b1; kind = hef_pkg::K_AMP;  need = 3'd5; end
        hef_pkg::CH_QUOT: begin is_seq = 1'b1; kind = hef_pkg::K_QUOT; need = 3'd6; end
        hef_pkg::CH_APOS: begin is_seq = 1'b1; kind = hef_pkg::K_APOS; need = 3'd6; end
        hef_pkg::CH_LF: begin
          if (st.run < limit) begin
            run_inc = 1'b1;
            is_seq  = 1'b1;
            kind    = hef_pkg::K_BR;
            need    = 3'd4;
          end
        end
        default: begin
          if ((data >= hef_pkg::CH_LO && data <= hef_pkg::CH_HI) || data[7]) begin
            kind = hef_pkg::K_PLAIN;
            need = 3'd1;
          end
        end
      endcase

      room = (cnt_x + hef_pkg::CMP_W'(need) + hef_pkg::CMP_W'(1)) < cap_x;
      if (is_seq && !room) begin
        fail = hef_pkg::ST_ROOM;
        kind = hef_pkg::K_NONE;
        need = 3'd0;
      end

      sum     = cnt_x + hef_pkg::CMP_W'(need);
      cnt_new = (|sum[hef_pkg::CMP_W-1:hef_pkg::COUNT_BITS]) ? '1
                                                             : sum[hef_pkg::COUNT_BITS-1:0];
      run_new = run_inc ? st.run + 1'b1 : st.run;

      if (fail == hef_pkg::ST_OK) begin
        if (data != hef_pkg::CH_LF && data != hef_pkg::CH_CR) run_new = '0;
        if (last) begin
          trailer = 1'b1;
          cnt_new = '0;
          run_new = '0;
        end else if ((hef_pkg::CMP_W'(cnt_new) + hef_pkg::CMP_W'(1)) >= cap_x) begin
          fail = hef_pkg::ST_ROOM;
        end
      end

      if (fail != hef_pkg::ST_OK) begin
        trailer  = 1'b1;
        cnt_new  = '0;
        run_new  = '0;
        disc_new = !last;
      end
    end
  end

  always_comb begin
    plan             = '0;
    plan.kind        = kind;
    plan.len         = need;
    plan.trailer     = trailer;
    plan.status      = fail;
    plan.nres        = need + {2'b00, trailer};
    plan.st_nxt.cnt  = cnt_new;
    plan.st_nxt.run  = run_new;
    plan.st_nxt.disc = disc_new;
  end

endmodule

[dv/html_escape_filter_top_test.sv]
`timescale 1ns / 100ps

module html_escape_filter_top_test;
  import hef_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam longint unsigned CNT_MAX = (64'd1 << COUNT_BITS) - 1;

  typedef struct packed {
    logic [7:0] ch;
    logic       run_last;
    logic       done;
    logic [1:0] status;
  } esc_res_t;

  // Tracks the escaper's message state and holds the escaped text still owed by the block.
  class escape_board;
    esc_res_t        escaped_q[$];
    esc_res_t        batch[$];
    longint unsigned capacity;
    longint unsigned nl_limit;
    longint unsigned out_cnt;
    longint unsigned nl_run;
    bit              dropping;
    int              errors;

    function new();
      capacity = 256;
      nl_limit = 0;
      errors   = 0;
      clear_msg();
    endfunction

    function void clear_msg();
      out_cnt  = 0;
      nl_run   = 0;
      dropping = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == REG_CAPACITY) begin
        capacity = val;
      end else begin
        nl_limit = val[LIMIT_W-1:0];
      end
    endfunction

    function void emit(logic [7:0] ch, logic done, logic [1:0] st);
      esc_res_t r;
      r.ch       = ch;
      r.run_last = 1'b0;
      r.done     = done;
      r.status   = st;
      batch.push_back(r);
    endfunction

    function void bump(longint unsigned k);
      out_cnt = (out_cnt + k > CNT_MAX) ? CNT_MAX : out_cnt + k;
    endfunction

    function bit put_seq(string s);
      int i;
      if (out_cnt + s.len() + 1 >= capacity) return 1'b0;
      for (i = 0; i < s.len(); i++) emit(s[i], 1'b0, ST_OK);
      bump(s.len());
      return 1'b1;
    endfunction

    // escape one accepted byte and queue the text it should produce
    function void take_byte(logic [7:0] c, logic last);
      logic [1:0] why;
      bit         fits;
      why  = ST_OK;
      fits = 1'b1;
      batch.delete();
      if (dropping) begin
        if (last) clear_msg();
        return;
      end
      case (c)
        CH_NUL:  why = ST_NUL;
        CH_LT:   fits = put_seq("&lt;");
        CH_GT:   fits = put_seq("&gt;");
        CH_AMP:  fits = put_seq("&amp;");
        CH_QUOT: fits = put_seq("&quot;");
        CH_APOS: fits = put_seq("&apos;");
        CH_LF: begin
          if (nl_run < nl_limit) begin
            nl_run++;
            fits = put_seq("<br>");
          end
        end
        default: begin
          if ((c >= CH_LO && c <= CH_HI) || c[7]) begin
            emit(c, 1'b0, ST_OK);
            bump(1);
          end
        end
      endcase
      if (!fits) why = ST_ROOM;
      if (why == ST_OK) begin
        if (c != CH_LF && c != CH_CR) nl_run = 0;
        if (last) begin
          emit(8'h00, 1'b1, ST_OK);
          clear_msg();
        end else if (out_cnt + 1 >= capacity) begin
          why = ST_ROOM;
        end
      end
      if (why != ST_OK) begin
        emit(8'h00, 1'b1, why);
        clear_msg();
        dropping = !last;
      end
      if (batch.size() > 0) batch[batch.size()-1].run_last = 1'b1;
      foreach (batch[i]) escaped_q.push_back(batch[i]);
    endfunction

    function void match_result(logic [7:0] ch, logic rl, logic done, logic [1:0] st);
      esc_res_t e;
      if (escaped_q.size() == 0) begin
        $error("out_byte: expected none, got %0h", ch);
        errors++;
        return;
      end
      e = escaped_q.pop_front();
      if (ch !== e.ch) begin
        $error("out_byte: expected %0h, got %0h", e.ch, ch);
        errors++;
      end
      if (rl !== e.run_last) begin
        $error("out_run_last: expected %0d, got %0d", e.run_last, rl);
        errors++;
      end
      if (done !== e.done) begin
        $error("out_message_done: expected %0d, got %0d", e.done, done);
        errors++;
      end
      if (st !== e.status) begin
        $error("out_status: expected %0d, got %0d", e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       in_data_byte;
  logic             in_last_byte;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_byte;
  logic             out_run_last;
  logic             out_message_done;
  logic [1:0]       out_status;
  logic             cfg_we;
  logic             cfg_index;
  logic [CFG_W-1:0] cfg_data;

  escape_board sb;
  logic [7:0]  msg[$];
  bit          hold_long = 1'b0;
  bit          calm = 1'b0;
  int          cycles = 0;

  html_escape_filter_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .in_last_byte     (in_last_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_run_last     (out_run_last),
    .out_message_done (out_message_done),
    .out_status       (out_status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid && out_ready)
      sb.match_result(out_byte, out_run_last, out_message_done, out_status);
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (hold_long) begin
        hold_long = 1'b0;
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 25)) @(posedge clk);
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic last);
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    sb.take_byte(d, last);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic send_msg();
    int i;
    for (i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
    msg.delete();
  endtask

  // a byte that gives no result may still be in flight when the queue empties
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.escaped_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_config(input logic [CAP_W-1:0] cap, input logic [LIMIT_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CAPACITY;
    cfg_data  <= cap;
    @(posedge clk);
    sb.write_reg(REG_CAPACITY, cap);
    cfg_index <= REG_NL_LIMIT;
    cfg_data  <= CFG_W'(lim);
    @(posedge clk);
    sb.write_reg(REG_NL_LIMIT, CFG_W'(lim));
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 8'($urandom_range(32, 126));
    if (r < 55) begin
      case ($urandom_range(0, 4))
        0:       return CH_LT;
        1:       return CH_GT;
        2:       return CH_AMP;
        3:       return CH_QUOT;
        default: return CH_APOS;
      endcase
    end
    if (r < 70) return CH_LF;
    if (r < 75) return CH_CR;
    if (r < 85) return 8'($urandom_range(128, 255));
    if (r < 91) return ($urandom_range(0, 3) == 0) ? 8'h7F : 8'($urandom_range(1, 31));
    if (r < 94) return CH_NUL;
    return 8'($urandom);
  endfunction

  task automatic rand_traffic(input int n);
    int sent;
    int len;
    int i;
    int mode;
    sent = 0;
    while (sent < n) begin
      mode = $urandom_range(0, 9);
      len  = $urandom_range(1, 10);
      if (mode < 2) begin
        // noise: arbitrary bytes, arbitrary end flags
        len = $urandom_range(1, 4);
        for (i = 0; i < len; i++) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end else if (mode == 2) begin
        // newline run, broken up by the odd carriage return
        for (i = 0; i < len; i++)
          send_byte(($urandom_range(0, 4) == 0) ? CH_CR : CH_LF, i == len - 1);
      end else begin
        for (i = 0; i < len; i++) send_byte(pick_char(), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    sb = new();
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_data_byte <= 8'h00;
    in_last_byte <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_CAPACITY;
    cfg_data     <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: every entity, range edges, dropped controls, newline dropped at limit 0
    msg = '{CH_LT, CH_GT, CH_AMP, CH_QUOT, CH_APOS, 8'h20, 8'h7E, 8'h80, 8'hFF,
            8'h7F, 8'h01, CH_LF, CH_CR, 8'h41};
    send_msg();
    // NUL at the start of a message: rest is discarded through the last byte
    msg = '{CH_NUL, 8'h78, 8'h79};
    send_msg();
    msg = '{CH_NUL};
    send_msg();

    // smallest buffer: room runs out after a byte, before an entity, before a line break
    drain();
    set_config(CAP_W'(2), LIMIT_W'(255));
    msg = '{8'h61};
    send_msg();
    msg = '{8'h61, 8'h62};
    send_msg();
    msg = '{CH_LT};
    send_msg();
    msg = '{CH_LF};
    send_msg();

    drain();
    set_config(CAP_W'($urandom_range(2, 24)), LIMIT_W'($urandom_range(0, 3)));
    rand_traffic(15);

    drain();
    set_config(CAP_W'(65535), LIMIT_W'(255));
    hold_long = 1'b1;
    rand_traffic(15);

    drain();
    set_config(CAP_W'($urandom_range(2, 65535)), LIMIT_W'($urandom_range(0, 255)));
    rand_traffic(7);
    drain();
    rand_traffic(8);

    drain();
    calm = 1'b1;
    set_config(CAP_W'($urandom_range(8, 60)), LIMIT_W'($urandom_range(1, 4)));
    rand_traffic(15);

    in_valid <= 1'b0;
    while (sb.escaped_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (sb.escaped_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.escaped_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
